// ----- design/mplc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplc_pkg
// Shared widths, constants, band weights and sigmoid table for the
// mean-pool logistic classifier.
// ----------------------------------------------------------------------------
package mplc_pkg;

    localparam int BANDS_DEF      = 40;
    localparam int MAX_FRAMES_DEF = 255;

    localparam int FEAT_W   = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 48;
    localparam int BAND_W   = 6;
    localparam int FRAME_W  = 8;
    localparam int DIVD_W   = 49;
    localparam int DIVS_W   = 12;
    localparam int SCORE_W  = 32;
    localparam int PROB_W   = 16;
    localparam int SIG_W    = 17;
    localparam int FRAC_W   = 14;
    localparam int SIG_STEPS = 48;

    localparam logic signed [SCORE_W-1:0] BIAS_Q16 = -32'sd2087193;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    function automatic logic signed [FEAT_W-1:0] band_weight(input logic [BAND_W-1:0] b);
        logic signed [FEAT_W-1:0] w;
        case (b)
            6'd0:  w = -16'sd3551;
            6'd1:  w = -16'sd1818;
            6'd2:  w =  16'sd3257;
            6'd3:  w =  16'sd3836;
            6'd4:  w = -16'sd3446;
            6'd5:  w = -16'sd4305;
            6'd6:  w =  16'sd1438;
            6'd7:  w = -16'sd231;
            6'd8:  w =  16'sd4951;
            6'd9:  w =  16'sd2392;
            6'd10: w = -16'sd1812;
            6'd11: w = -16'sd4330;
            6'd12: w =  16'sd1121;
            6'd13: w =  16'sd2529;
            6'd14: w =  16'sd3200;
            6'd15: w =  16'sd1171;
            6'd16: w =  16'sd560;
            6'd17: w = -16'sd684;
            6'd18: w =  16'sd3220;
            6'd19: w =  16'sd372;
            6'd20: w =  16'sd2966;
            6'd21: w =  16'sd1024;
            6'd22: w =  16'sd2515;
            6'd23: w = -16'sd404;
            6'd24: w =  16'sd6484;
            6'd25: w =  16'sd5427;
            6'd26: w =  16'sd3598;
            6'd27: w = -16'sd12094;
            6'd28: w = -16'sd8520;
            6'd29: w = -16'sd8694;
            6'd30: w =  16'sd75;
            6'd31: w =  16'sd1354;
            6'd32: w = -16'sd2965;
            6'd33: w = -16'sd4437;
            6'd34: w =  16'sd4055;
            6'd35: w =  16'sd1347;
            6'd36: w = -16'sd589;
            6'd37: w = -16'sd432;
            6'd38: w =  16'sd6369;
            6'd39: w =  16'sd9520;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [SIG_W-1:0] sig_lut(input logic [BAND_W-1:0] k);
        logic [SIG_W-1:0] v;
        case (k)
            6'd0:  v = 17'd32768;
            6'd1:  v = 17'd36843;
            6'd2:  v = 17'd40793;
            6'd3:  v = 17'd44511;
            6'd4:  v = 17'd47911;
            6'd5:  v = 17'd50941;
            6'd6:  v = 17'd53581;
            6'd7:  v = 17'd55834;
            6'd8:  v = 17'd57724;
            6'd9:  v = 17'd59287;
            6'd10: v = 17'd60565;
            6'd11: v = 17'd61598;
            6'd12: v = 17'd62428;
            6'd13: v = 17'd63090;
            6'd14: v = 17'd63615;
            6'd15: v = 17'd64030;
            6'd16: v = 17'd64357;
            6'd17: v = 17'd64614;
            6'd18: v = 17'd64816;
            6'd19: v = 17'd64974;
            6'd20: v = 17'd65097;
            6'd21: v = 17'd65194;
            6'd22: v = 17'd65269;
            6'd23: v = 17'd65328;
            6'd24: v = 17'd65374;
            6'd25: v = 17'd65410;
            6'd26: v = 17'd65438;
            6'd27: v = 17'd65459;
            6'd28: v = 17'd65476;
            6'd29: v = 17'd65489;
            6'd30: v = 17'd65500;
            6'd31: v = 17'd65508;
            6'd32: v = 17'd65514;
            6'd33: v = 17'd65519;
            6'd34: v = 17'd65523;
            6'd35: v = 17'd65526;
            6'd36: v = 17'd65528;
            6'd37: v = 17'd65530;
            6'd38: v = 17'd65531;
            6'd39: v = 17'd65532;
            6'd40: v = 17'd65533;
            6'd41: v = 17'd65534;
            6'd42: v = 17'd65534;
            6'd43: v = 17'd65535;
            6'd44: v = 17'd65535;
            6'd45: v = 17'd65535;
            6'd46: v = 17'd65535;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

// ----- design/mplc_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplc_ifs
// Valid/ready channels of the classifier: feature input and result output.
// ----------------------------------------------------------------------------
interface mplc_feature_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] feature;
    logic               last;

    modport source (output valid, output feature, output last, input ready);
    modport sink   (input valid, input feature, input last, output ready);
endinterface

interface mplc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] score;
    logic        [15:0] probability;

    modport source (output valid, output score, output probability, input ready);
    modport sink   (input valid, input score, input probability, output ready);
endinterface

// ----- design/mplc_mult.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplc_mult
// Shared signed 16x16 multiplier with registered product, used for the
// band weighting and for the sigmoid interpolation.
// ----------------------------------------------------------------------------
module mplc_mult
    import mplc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [FEAT_W-1:0] i_a,
    input  logic signed [FEAT_W-1:0] i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// ----- design/mplc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplc_divider
// Restoring divider, one quotient bit per cycle, for the mean over frames.
// ----------------------------------------------------------------------------
module mplc_divider
    import mplc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output t_div_status       o_status,
    output logic [DIVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_div;
    logic [DIVD_W-1:0] r_quo;

    logic [DIVS_W:0]   w_trial;
    logic              w_ge;
    logic [DIVS_W:0]   w_diff;

    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DIVS_W-1:0] : w_trial[DIVS_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

// ----- design/mean_pool_logistic_classifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_pool_logistic_classifier_unit
// Logistic-regression clip scorer over mean-pooled mel-band features.
// ----------------------------------------------------------------------------
// i_in carries one Q7.8 band value per transaction, BANDS values per frame in
// band order, with last set on the final value of a clip. Each value is
// weighted by the shared multiplier and added to a 48-bit sum; i_in is
// ready only in the idle state, so no new value is taken while one is added.
// On a last value the sum is divided by the frame count in a bit-serial
// divider (one quotient bit at a time), the bias is added and the
// sigmoid is interpolated from a table using the same multiplier. o_out
// shows score (Q15.16) and probability (Q0.16) once the sigmoid is done;
// i_in is held off from the last value until that result is registered.
// A finished result sits in the o_out register; the block takes new values
// while it waits, and only holds at the end of the next clip if the
// receiver still stalls o_out. Values past MAX_FRAMES frames are dropped.
// Synchronous reset clears the sum, counters and o_out valid.
// ----------------------------------------------------------------------------
module mean_pool_logistic_classifier_unit
    import mplc_pkg::*;
#(
    parameter int BANDS      = BANDS_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mplc_feature_if.sink  i_in,
    mplc_result_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_PREP,
        S_DIV,
        S_SCORE,
        S_SIGM,
        S_SIGF
    } t_state;

    localparam logic signed [50:0] SAT_HI = 51'sh0_0000_7FFF_FFFF;
    localparam logic signed [50:0] SAT_LO = {{20{1'b1}}, 31'd0};

    t_state                     r_state;
    logic signed [SUM_W-1:0]    r_sum;
    logic [BAND_W-1:0]          r_bp;
    logic [FRAME_W-1:0]         r_frames;
    logic                       r_last;
    logic                       r_neg;
    logic signed [SCORE_W-1:0]  r_score;
    logic                       r_out_valid;
    logic signed [SCORE_W-1:0]  r_out_score;
    logic [PROB_W-1:0]          r_out_prob;

    logic                       w_accept;
    logic                       w_mul_en;
    logic signed [FEAT_W-1:0]   w_mul_a;
    logic signed [FEAT_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;

    logic [FRAME_W:0]           w_frames;
    logic [FRAME_W-1:0]         w_frames_g;
    logic [SUM_W-1:0]           w_mag;
    logic [DIVD_W-1:0]          w_dividend;
    logic [DIVS_W-1:0]          w_divisor;
    logic                       w_div_start;
    t_div_status                w_div_status;
    logic [DIVD_W-1:0]          w_quo;

    logic signed [50:0]         w_q_s;
    logic signed [50:0]         w_total;
    logic signed [SCORE_W-1:0]  w_sat;

    logic [SCORE_W-1:0]         w_abs;
    logic                       w_big;
    logic [BAND_W-1:0]          w_idx;
    logic [SIG_W-1:0]           w_lo;
    logic [SIG_W-1:0]           w_hi;
    logic [SIG_W-1:0]           w_dlt;
    logic [PROD_W-1:0]          w_rnd;
    logic [SIG_W-1:0]           w_v;
    logic [PROB_W-1:0]          w_prob;

    assign w_accept = i_in.valid && i_in.ready;

    // weighting and sigmoid interpolation share the multiplier
    assign w_mul_en = w_accept || ((r_state == S_SIGM) && !w_big);
    assign w_mul_a  = (r_state == S_IDLE) ? i_in.feature : w_dlt[FEAT_W-1:0];
    assign w_mul_b  = (r_state == S_IDLE) ? band_weight(r_bp)
                                          : {2'b00, w_abs[FRAC_W-1:0]};

    mplc_mult u_mult (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // frame count, a partial final frame counts whole
    assign w_frames   = {1'b0, r_frames} + {{FRAME_W{1'b0}}, (r_bp != '0)};
    assign w_frames_g = (w_frames == '0) ? FRAME_W'(1) : w_frames[FRAME_W-1:0];
    assign w_mag      = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;
    assign w_divisor  = {w_frames_g, 4'b0000};
    assign w_dividend = {1'b0, w_mag} + {{(DIVD_W-FRAME_W-3){1'b0}}, w_frames_g, 3'b000};
    assign w_div_start = (r_state == S_PREP);

    mplc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_status   (w_div_status),
        .o_quotient (w_quo)
    );

    // signed mean plus bias, saturated
    assign w_q_s   = r_neg ? -$signed({2'b00, w_quo}) : $signed({2'b00, w_quo});
    assign w_total = w_q_s + {{19{BIAS_Q16[SCORE_W-1]}}, BIAS_Q16};
    assign w_sat   = (w_total > SAT_HI) ? SCORE_W'(SAT_HI) :
                     (w_total < SAT_LO) ? SCORE_W'(SAT_LO) : w_total[SCORE_W-1:0];

    // sigmoid by table and linear interpolation
    assign w_abs = r_score[SCORE_W-1] ? SCORE_W'(-r_score) : r_score;
    assign w_big = (w_abs[SCORE_W-1:FRAC_W] >= (SCORE_W-FRAC_W)'(SIG_STEPS));
    assign w_idx = w_abs[FRAC_W+BAND_W-1:FRAC_W];
    assign w_lo  = sig_lut(w_idx);
    assign w_hi  = sig_lut(w_idx + 1'b1);
    assign w_dlt = w_hi - w_lo;
    assign w_rnd = w_prod + PROD_W'(8192);
    assign w_v   = w_big ? SIG_W'(65536) : (w_lo + w_rnd[FRAC_W+SIG_W-1:FRAC_W]);
    always_comb begin
        logic [SIG_W-1:0] neg_v;
        neg_v = SIG_W'(65536) - w_v;
        if (!r_score[SCORE_W-1]) begin
            w_prob = w_v[SIG_W-1] ? {PROB_W{1'b1}} : w_v[PROB_W-1:0];
        end else begin
            w_prob = neg_v[PROB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_bp        <= '0;
            r_frames    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_SIGF)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last  <= i_in.last;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_frames < FRAME_W'(MAX_FRAMES)) begin
                        r_sum <= r_sum + SUM_W'(w_prod);
                        if (r_bp == BAND_W'(BANDS - 1)) begin
                            r_bp     <= '0;
                            r_frames <= r_frames + 1'b1;
                        end else begin
                            r_bp <= r_bp + 1'b1;
                        end
                    end
                    r_state <= r_last ? S_PREP : S_IDLE;
                end
                S_PREP: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_status.done) begin
                        r_state <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    r_score <= w_sat;
                    r_state <= S_SIGM;
                end
                S_SIGM: begin
                    r_state <= S_SIGF;
                end
                S_SIGF: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_score <= r_score;
                        r_out_prob  <= w_prob;
                        r_sum       <= '0;
                        r_bp        <= '0;
                        r_frames    <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.score       = r_out_score;
    assign o_out.probability = r_out_prob;

    // divider only runs while the sequencer waits on it
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_status.busy |-> (r_state == S_DIV))
        else $error("divider busy outside divide state");

    // a new result only comes from the final sigmoid step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_SIGF))
        else $error("result raised outside sigmoid step");

    // band and frame counters stay in range
    a_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bp <= BAND_W'(BANDS - 1)) && (r_frames <= FRAME_W'(MAX_FRAMES)))
        else $error("band or frame counter out of range");

endmodule

// ----- test/tb_mean_pool_logistic_classifier_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mean_pool_logistic_classifier_unit
// Drives clips of Q7.8 mel-band values into the classifier. Each clip runs
// from its first value to the value marked last. The testbench keeps its own
// weighted sum, band and frame counters and sigmoid table. From these it
// predicts the score and probability of every clip, and a scoreboard checks
// each result transaction field by field against the oldest prediction.
// Clips are short or partial frames, whole frames at full or small range
// and peak-weighted frames. Both channels idle in random bursts. The
// receiver once holds off for a long stretch, and the sender drains the
// block completely once mid-run and again at the end.
// ----------------------------------------------------------------------------
module tb_mean_pool_logistic_classifier_unit
    import mplc_pkg::*;
();

    localparam int     CLK_HALF_NS  = 5;
    localparam int     ITEM_TARGET  = 1000;
    localparam int     CLIP_TARGET  = 36;
    localparam int     LONG_HOLD    = 2000;
    localparam int     DRAIN_CYCLES = 100;
    localparam longint TIMEOUT_NS   = 64'd10_000_000;

    localparam int WEIGHT_Q12 [BANDS_DEF] = '{
        -3551, -1818,  3257,  3836, -3446, -4305,  1438,  -231,
         4951,  2392, -1812, -4330,  1121,  2529,  3200,  1171,
          560,  -684,  3220,   372,  2966,  1024,  2515,  -404,
         6484,  5427,  3598,-12094, -8520, -8694,    75,  1354,
        -2965, -4437,  4055,  1347,  -589,  -432,  6369,  9520
    };

    localparam int SIG_Q16 [SIG_STEPS+1] = '{
        32768, 36843, 40793, 44511, 47911, 50941, 53581, 55834,
        57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
        64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
        65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508,
        65514, 65519, 65523, 65526, 65528, 65530, 65531, 65532,
        65533, 65534, 65534, 65535, 65535, 65535, 65535, 65536,
        65536
    };

    typedef enum {
        CLIP_RANDOM,
        CLIP_SMALL,
        CLIP_PEAK_HIGH,
        CLIP_PEAK_LOW
    } t_clip_kind;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [PROB_W-1:0]  probability;
    } t_clip_result;

    class clip_scorer;
        longint       weighted_acc;
        int unsigned  band_idx;
        int unsigned  frame_cnt;
        t_clip_result expected_scores[$];
        int unsigned  clips_closed;
        int unsigned  failures;

        function new();
            clear_clip();
            clips_closed = 0;
            failures     = 0;
        endfunction

        function void clear_clip();
            weighted_acc = 0;
            band_idx     = 0;
            frame_cnt    = 0;
        endfunction

        function int unsigned pending();
            return expected_scores.size();
        endfunction

        function logic [PROB_W-1:0] sigmoid_q16(longint s);
            longint mag, idx, frac, v;
            mag  = (s < 0) ? -s : s;
            idx  = mag >>> FRAC_W;
            frac = mag & 16383;
            if (idx >= SIG_STEPS) begin
                v = 65536;
            end else begin
                v = SIG_Q16[idx] +
                    (((SIG_Q16[idx+1] - SIG_Q16[idx]) * frac + 8192) >>> FRAC_W);
            end
            if (s >= 0) begin
                v = (v > 65535) ? 65535 : v;
            end else begin
                v = 65536 - v;
            end
            return v[PROB_W-1:0];
        endfunction

        function void note_feature(logic signed [FEAT_W-1:0] feature, logic last);
            longint       frames, div, mag, q, s;
            t_clip_result r;
            // values past the frame limit are dropped
            if (frame_cnt < MAX_FRAMES_DEF) begin
                weighted_acc += longint'(feature) * WEIGHT_Q12[band_idx];
                band_idx++;
                if (band_idx >= BANDS_DEF) begin
                    band_idx = 0;
                    frame_cnt++;
                end
            end
            if (!last) begin
                return;
            end
            // a partial final frame counts as a whole one
            frames = frame_cnt + ((band_idx != 0) ? 1 : 0);
            if (frames == 0) begin
                frames = 1;
            end
            div = frames * 16;
            mag = (weighted_acc < 0) ? -weighted_acc : weighted_acc;
            q   = (mag + div / 2) / div;
            s   = ((weighted_acc < 0) ? -q : q) + longint'(BIAS_Q16);
            if (s > 64'sd2147483647) begin
                s = 64'sd2147483647;
            end
            if (s < -64'sd2147483648) begin
                s = -64'sd2147483648;
            end
            r.score       = s[SCORE_W-1:0];
            r.probability = sigmoid_q16(s);
            expected_scores.push_back(r);
            clips_closed++;
            clear_clip();
        endfunction

        function void check_result(logic signed [SCORE_W-1:0] score,
                                   logic [PROB_W-1:0] probability);
            t_clip_result e;
            if (expected_scores.size() == 0) begin
                $error("result with no clip pending: score %0d probability %0d",
                       score, probability);
                failures++;
                return;
            end
            e = expected_scores.pop_front();
            if (score !== e.score) begin
                $error("score: expected %0d, got %0d", e.score, score);
                failures++;
            end
            if (probability !== e.probability) begin
                $error("probability: expected %0d, got %0d", e.probability, probability);
                failures++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mplc_feature_if feat_if();
    mplc_result_if  res_if();

    clip_scorer  scorer = new();
    bit          quiet_mode;
    bit          long_hold_req;
    int unsigned counted_items;

    mean_pool_logistic_classifier_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (feat_if),
        .o_out   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // receiver: random stalls, one long hold-off, none at the end
    initial begin
        forever begin
            if (long_hold_req) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat (quiet_mode ? 1 : $urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            scorer.check_result(res_if.score, res_if.probability);
        end
    end

    task automatic idle_gap(input int unsigned cycles);
        feat_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        feat_if.valid <= 1'b0;
        @(posedge i_clk);
        while (scorer.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_feature(input logic signed [FEAT_W-1:0] feature, input logic last);
        if (!quiet_mode && $urandom_range(0, 4) == 0) begin
            idle_gap($urandom_range(1, 14));
        end
        feat_if.valid   <= 1'b1;
        feat_if.feature <= feature;
        feat_if.last    <= last;
        @(posedge i_clk);
        while (!feat_if.ready) @(posedge i_clk);
        scorer.note_feature(feature, last);
    endtask

    function automatic logic signed [FEAT_W-1:0] pick_feature(t_clip_kind kind,
                                                              int unsigned band);
        int v;
        case (kind)
            CLIP_PEAK_HIGH: v = (WEIGHT_Q12[band] < 0) ? -32768 : 32767;
            CLIP_PEAK_LOW:  v = (WEIGHT_Q12[band] < 0) ? 32767 : -32768;
            CLIP_SMALL:     v = int'($urandom_range(0, 1023)) - 512;
            default:        v = int'($urandom_range(0, 65535));
        endcase
        return v[FEAT_W-1:0];
    endfunction

    task automatic send_clip(input t_clip_kind kind, input int unsigned length,
                             input bit counted);
        for (int unsigned k = 0; k < length; k++) begin
            send_feature(pick_feature(kind, k % BANDS_DEF), k == length - 1);
            if (counted) begin
                counted_items++;
            end
        end
    endtask

    task automatic send_random_clip();
        t_clip_kind  kind;
        int unsigned length;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                kind   = CLIP_RANDOM;
                length = $urandom_range(1, BANDS_DEF - 1);
            end
            4, 5: begin
                kind   = CLIP_SMALL;
                length = $urandom_range(BANDS_DEF + 1, 2 * BANDS_DEF + 10);
            end
            6: begin
                kind   = CLIP_RANDOM;
                length = BANDS_DEF * $urandom_range(1, 2);
            end
            7: begin
                kind   = CLIP_PEAK_HIGH;
                length = BANDS_DEF * $urandom_range(1, 2);
            end
            8: begin
                kind   = CLIP_PEAK_LOW;
                length = BANDS_DEF * $urandom_range(1, 2);
            end
            default: begin
                kind   = CLIP_SMALL;
                length = $urandom_range(1, 12);
            end
        endcase
        send_clip(kind, length, 1'b1);
    endtask

    initial begin
        int unsigned clip_no;
        clip_no          = 0;
        counted_items    = 0;
        i_rst_n         <= 1'b0;
        feat_if.valid   <= 1'b0;
        feat_if.feature <= '0;
        feat_if.last    <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-value clips at the extremes and zero, then a few short mixed clips
        send_feature(16'sh8000, 1'b1);
        send_feature(16'sh7fff, 1'b1);
        send_feature(16'sh0000, 1'b1);
        send_feature(16'sh7fff, 1'b0);
        send_feature(16'sh8000, 1'b0);
        send_feature(16'sh0001, 1'b0);
        send_feature(16'shffff, 1'b0);
        send_feature(16'sh00ff, 1'b1);
        send_feature(16'shffff, 1'b0);
        send_feature(16'sh5555, 1'b0);
        send_feature(16'shaaaa, 1'b1);
        send_feature(16'sh8000, 1'b0);
        send_feature(16'sh8000, 1'b1);

        while (counted_items < ITEM_TARGET || scorer.clips_closed < CLIP_TARGET) begin
            clip_no++;
            if (counted_items >= ITEM_TARGET * 85 / 100) begin
                quiet_mode = 1'b1;
            end
            if (clip_no == 4) begin
                long_hold_req = 1'b1;
            end
            if (clip_no == 10) begin
                wait_drained();
            end
            send_random_clip();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scorer.failures == 0 && scorer.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
design/mplc_pkg.sv
design/mplc_ifs.sv
design/mplc_mult.sv
design/mplc_divider.sv
design/mean_pool_logistic_classifier_unit.sv
test/tb_mean_pool_logistic_classifier_unit.sv
